// ----- rtl/gsl_pkg.sv -----
// ----------------------------------------------------------------------------
// gsl_pkg: shared types and constants for the glyph slot cache
// field widths of the channel words, slot entry layout and sequencer states
// ----------------------------------------------------------------------------
package gsl_pkg;

    localparam int CODE_W  = 21;
    localparam int STAMP_W = 32;
    localparam int INDEX_W = 8;

    // one slot as held in the slot memory
    typedef struct packed {
        logic               valid;
        logic [CODE_W-1:0]  code;
        logic [STAMP_W-1:0] stamp;
    } slot_entry_t;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_LAST  = 5'b01000,
        ST_WRITE = 5'b10000
    } state_t;

endpackage

// ----- rtl/gsl_if.sv -----
// ----------------------------------------------------------------------------
// gsl_if: valid/ready channels of the glyph slot cache
// request channel carries a code point, response channel a slot and hit flag
// ----------------------------------------------------------------------------
interface gsl_req_if;
    logic                        valid;
    logic                        ready;
    logic [gsl_pkg::CODE_W-1:0]  char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface gsl_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [gsl_pkg::INDEX_W-1:0] slot_index;
    logic                        was_hit;

    modport source (output valid, output slot_index, output was_hit, input ready);
    modport sink   (input valid, input slot_index, input was_hit, output ready);
endinterface

// ----- rtl/glyph_slot_lru_cache.sv -----
// ----------------------------------------------------------------------------
// glyph_slot_lru_cache: fully associative glyph slot cache, lru by timestamp
// looks a code point up among the slots; on a miss the oldest slot is refilled
// ----------------------------------------------------------------------------
//
//  channel | role | word
//  --------+------+-------------------------------------------------
//  req     | sink | char_code (21 b)
//  rsp     | src  | slot_index (8 b, low bits of slot), was_hit (1 b)
//
// each word runs a single-port read scan of the slot memory, one entry per cycle,
// then the last and write steps, before the next word is accepted
// after reset a clearing pass writes every slot, req not ready
// the result sits in an output register; the next word is accepted while it waits
// a second result waits in the write step until the output register is free
//
module glyph_slot_lru_cache #(
    parameter int SLOT_COUNT = 256
) (
    input  logic      clk,
    input  logic      rst_n,
    gsl_req_if.sink   req,
    gsl_rsp_if.source rsp
);

    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int XW = (AW > gsl_pkg::INDEX_W) ? AW : gsl_pkg::INDEX_W;
    localparam logic [AW-1:0] LAST_IDX = AW'(SLOT_COUNT - 1);

    // slot memory: valid, code and stamp of every slot, registered read
    gsl_pkg::slot_entry_t slot_mem [SLOT_COUNT];

    gsl_pkg::state_t state_reg, state_next;
    logic [AW-1:0]   cnt_reg, cnt_next;

    logic [gsl_pkg::STAMP_W-1:0] use_counter_reg, use_counter_next;
    logic [gsl_pkg::CODE_W-1:0]  code_reg, code_next;

    // read data pipe
    gsl_pkg::slot_entry_t rd_data_reg;
    logic                 rd_vld_reg, rd_vld_next;
    logic [AW-1:0]        rd_idx_reg;

    // search trackers
    logic                        hit_found_reg, hit_found_next;
    logic [AW-1:0]               hit_idx_reg, hit_idx_next;
    logic [gsl_pkg::STAMP_W-1:0] best_age_reg, best_age_next;
    logic [AW-1:0]               best_idx_reg, best_idx_next;

    // output register
    logic                       out_vld_reg, out_vld_next;
    logic [gsl_pkg::INDEX_W-1:0] out_idx_reg, out_idx_next;
    logic                       out_hit_reg, out_hit_next;

    // memory ports
    logic                 mem_re;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    gsl_pkg::slot_entry_t mem_wdata;

    logic [gsl_pkg::STAMP_W-1:0] age;
    logic                        older;
    logic                        match;
    logic                        wr_go;
    logic [AW-1:0]               sel_idx;
    logic [XW-1:0]               sel_idx_ext;

    assign req.ready   = (state_reg == gsl_pkg::ST_IDLE);
    assign rsp.valid   = out_vld_reg;
    assign rsp.slot_index = out_idx_reg;
    assign rsp.was_hit = out_hit_reg;

    // wrapping age of the entry just read, and its comparisons
    assign age   = use_counter_reg - rd_data_reg.stamp;
    assign older = (rd_idx_reg == '0) || (age > best_age_reg);
    assign match = rd_data_reg.valid && (rd_data_reg.code == code_reg);

    // the write step waits only while an earlier result is still unread
    assign wr_go = !out_vld_reg || rsp.ready;

    // hit slot wins; otherwise the oldest slot, lowest index on a tie
    assign sel_idx     = hit_found_reg ? hit_idx_reg : best_idx_reg;
    assign sel_idx_ext = XW'(sel_idx);

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        use_counter_next = use_counter_reg;
        code_next        = code_reg;
        rd_vld_next      = 1'b0;
        hit_found_next   = hit_found_reg;
        hit_idx_next     = hit_idx_reg;
        best_age_next    = best_age_reg;
        best_idx_next    = best_idx_reg;
        out_vld_next     = out_vld_reg && !rsp.ready;
        out_idx_next     = out_idx_reg;
        out_hit_next     = out_hit_reg;
        mem_re           = 1'b0;
        mem_we           = 1'b0;
        mem_waddr        = cnt_reg;
        mem_wdata        = '0;

        // fold in the entry returned by last cycle's read
        if (rd_vld_reg)
        begin
            if (match && !hit_found_reg)
            begin
                hit_found_next = 1'b1;
                hit_idx_next   = rd_idx_reg;
            end
            if (older)
            begin
                best_age_next = age;
                best_idx_next = rd_idx_reg;
            end
        end

        case (state_reg)
            gsl_pkg::ST_CLEAR:
            begin
                mem_we = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    cnt_next   = '0;
                    state_next = gsl_pkg::ST_IDLE;
                end
            end
            gsl_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    code_next      = req.char_code;
                    hit_found_next = 1'b0;
                    cnt_next       = '0;
                    state_next     = gsl_pkg::ST_SCAN;
                end
            end
            gsl_pkg::ST_SCAN:
            begin
                mem_re      = 1'b1;
                rd_vld_next = 1'b1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    cnt_next   = '0;
                    state_next = gsl_pkg::ST_LAST;
                end
            end
            gsl_pkg::ST_LAST:
            begin
                state_next = gsl_pkg::ST_WRITE;
            end
            gsl_pkg::ST_WRITE:
            begin
                if (wr_go)
                begin
                    // hit refreshes the stamp, miss refills the victim
                    mem_we          = 1'b1;
                    mem_waddr       = sel_idx;
                    mem_wdata.valid = 1'b1;
                    mem_wdata.code  = code_reg;
                    mem_wdata.stamp = use_counter_reg + 1'b1;
                    use_counter_next = use_counter_reg + 1'b1;
                    out_vld_next    = 1'b1;
                    out_idx_next    = sel_idx_ext[gsl_pkg::INDEX_W-1:0];
                    out_hit_next    = hit_found_reg;
                    state_next      = gsl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gsl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= gsl_pkg::ST_CLEAR;
            cnt_reg         <= '0;
            use_counter_reg <= '0;
            rd_vld_reg      <= 1'b0;
            hit_found_reg   <= 1'b0;
            out_vld_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            use_counter_reg <= use_counter_next;
            rd_vld_reg      <= rd_vld_next;
            hit_found_reg   <= hit_found_next;
            out_vld_reg     <= out_vld_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        code_reg     <= code_next;
        hit_idx_reg  <= hit_idx_next;
        best_age_reg <= best_age_next;
        best_idx_reg <= best_idx_next;
        out_idx_reg  <= out_idx_next;
        out_hit_reg  <= out_hit_next;
        rd_idx_reg   <= cnt_reg;
    end

    // slot memory, one write and one read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= slot_mem[cnt_reg];
        end
    end

    // a finished write step always leaves a result in the output register
    a_write_gives_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == gsl_pkg::ST_WRITE && wr_go) |=> out_vld_reg
    ) else $error("write step did not load the output register");

    // the use counter steps by one per word and only in the write step
    a_counter_step: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == gsl_pkg::ST_WRITE && wr_go)
            |=> (use_counter_reg == $past(use_counter_reg) + 1'b1)
    ) else $error("use counter did not advance on write");

    a_counter_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        !(state_reg == gsl_pkg::ST_WRITE && wr_go) |=> $stable(use_counter_reg)
    ) else $error("use counter moved outside the write step");

    // read data only returns during the scan and the last step
    a_read_in_scan: assert property (
        @(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> (state_reg == gsl_pkg::ST_SCAN || state_reg == gsl_pkg::ST_LAST)
    ) else $error("memory read data outside the scan");

endmodule

// ----- dv/glyph_slot_lru_cache_tb.sv -----
// ----------------------------------------------------------------------------
// glyph_slot_lru_cache_tb: self-checking bench for the glyph slot lru cache
// feeds code points through the request channel, predicts slot and hit flag
// with a timestamp lru table of its own, and checks every response word
// ----------------------------------------------------------------------------
module glyph_slot_lru_cache_tb;

    localparam int SLOTS    = 256;
    localparam int HALF_CLK = 6;
    localparam logic [gsl_pkg::CODE_W-1:0] CODE_MAX = {gsl_pkg::CODE_W{1'b1}};

    // idling modes, one per phase of the run
    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    // one response word as the bench expects it
    typedef struct packed {
        logic [gsl_pkg::INDEX_W-1:0] slot_index;
        logic                        was_hit;
    } slot_word_t;

    logic clk;
    logic rst_n;

    gsl_req_if req_ch ();
    gsl_rsp_if rsp_ch ();

    glyph_slot_lru_cache #(
        .SLOT_COUNT (SLOTS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // code points waiting to be offered, and slot words waiting to come back
    logic [gsl_pkg::CODE_W-1:0] code_pending  [$];
    slot_word_t                 slot_expected [$];

    // bench copy of the slot table
    logic                        shadow_valid [SLOTS];
    logic [gsl_pkg::CODE_W-1:0]  shadow_code  [SLOTS];
    logic [gsl_pkg::STAMP_W-1:0] shadow_stamp [SLOTS];
    logic [gsl_pkg::STAMP_W-1:0] shadow_clock;

    int send_idle_pct;
    int recv_stall_pct;
    int mismatch_count;

    // ------------------------------------------------------------------------
    // lookup or insert one code, returns the slot word the block should give
    // ------------------------------------------------------------------------
    function automatic slot_word_t lookup_glyph(input logic [gsl_pkg::CODE_W-1:0] code);
        slot_word_t                  word;
        int                          hit_at;
        int                          victim;
        logic [gsl_pkg::STAMP_W-1:0] oldest;
        logic [gsl_pkg::STAMP_W-1:0] age;
        hit_at = -1;
        for (int i = 0; i < SLOTS; i++)
        begin
            // lowest matching index wins, though duplicates should never occur
            if (hit_at < 0 && shadow_valid[i] && shadow_code[i] == code)
                hit_at = i;
        end
        if (hit_at >= 0)
        begin
            shadow_clock = shadow_clock + 1'b1;
            shadow_stamp[hit_at] = shadow_clock;
            word.slot_index = gsl_pkg::INDEX_W'(hit_at);
            word.was_hit    = 1'b1;
        end
        else
        begin
            // greatest wrapping age, ties to the lowest index; invalid slots
            // compete on their stamp like any other
            victim = 0;
            oldest = shadow_clock - shadow_stamp[0];
            for (int i = 1; i < SLOTS; i++)
            begin
                age = shadow_clock - shadow_stamp[i];
                if (age > oldest)
                begin
                    oldest = age;
                    victim = i;
                end
            end
            shadow_valid[victim] = 1'b1;
            shadow_code[victim]  = code;
            shadow_clock = shadow_clock + 1'b1;
            shadow_stamp[victim] = shadow_clock;
            word.slot_index = gsl_pkg::INDEX_W'(victim);
            word.was_hit    = 1'b0;
        end
        return word;
    endfunction

    // ------------------------------------------------------------------------
    // clock and reset
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        // nonblocking so the async reset edge is seen by every block at time 0
        rst_n <= 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        forever
        begin
            #(HALF_CLK) clk = ~clk;
        end
    end

    // hard stop, far beyond the slowest legal run
    initial
    begin
        #(2 * HALF_CLK * 3000000);
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------------
    // driver: offers queued codes, predicts each word as it is accepted
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid     <= 1'b0;
            req_ch.char_code <= '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                slot_expected.push_back(lookup_glyph(req_ch.char_code));
            // a word on offer is held until taken
            if (!req_ch.valid || req_ch.ready)
            begin
                if (code_pending.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req_ch.valid     <= 1'b1;
                    req_ch.char_code <= code_pending.pop_front();
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: random back-pressure, compares each response word in order
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (slot_expected.size() == 0)
                begin
                    $display("%0t unexpected word: slot_index %0d was_hit %0b",
                             $time, rsp_ch.slot_index, rsp_ch.was_hit);
                    mismatch_count++;
                end
                else
                begin
                    if (rsp_ch.slot_index !== slot_expected[0].slot_index)
                    begin
                        $display("%0t slot_index: expected %0d, actual %0d", $time,
                                 slot_expected[0].slot_index, rsp_ch.slot_index);
                        mismatch_count++;
                    end
                    if (rsp_ch.was_hit !== slot_expected[0].was_hit)
                    begin
                        $display("%0t was_hit: expected %0b, actual %0b", $time,
                                 slot_expected[0].was_hit, rsp_ch.was_hit);
                        mismatch_count++;
                    end
                    void'(slot_expected.pop_front());
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            IDLE_SENDER:
            begin
                send_idle_pct  = 77;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 77;
            end
            default:
            begin
                send_idle_pct  = 8;
                recv_stall_pct = 8;
            end
        endcase
    endtask

    // sender holds off until every queued word is taken and every answer is in
    task automatic wait_drained();
        @(negedge clk);
        while (code_pending.size() != 0 || req_ch.valid || slot_expected.size() != 0)
            @(negedge clk);
    endtask

    // mostly codes from a working set, so hits and evictions both happen;
    // the rest fully random codes, extremes and single-bit codes
    task automatic queue_random_phase(input int pool_size, input int word_count);
        logic [gsl_pkg::CODE_W-1:0] pool [$];
        int                         pick;
        for (int n = 0; n < pool_size; n++)
            pool.push_back(gsl_pkg::CODE_W'($urandom()));
        for (int n = 0; n < word_count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 75)
                code_pending.push_back(pool[$urandom_range(pool_size - 1)]);
            else if (pick < 90)
                code_pending.push_back(gsl_pkg::CODE_W'($urandom()));
            else if (pick < 95)
                code_pending.push_back(pick[0] ? CODE_MAX : '0);
            else
                code_pending.push_back(gsl_pkg::CODE_W'(1)
                                       << $urandom_range(gsl_pkg::CODE_W - 1));
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        mismatch_count = 0;
        shadow_clock   = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            shadow_valid[i] = 1'b0;
            shadow_code[i]  = '0;
            shadow_stamp[i] = '0;
        end
        set_idling(IDLE_NONE);
        @(posedge rst_n);

        // directed: empty table fills in index order, extremes of the code,
        // alternating bit patterns, then hits on codes already placed
        code_pending.push_back('0);
        code_pending.push_back(CODE_MAX);
        code_pending.push_back('0);
        code_pending.push_back(CODE_MAX);
        code_pending.push_back(21'h155555);
        code_pending.push_back(21'h0AAAAA);
        code_pending.push_back(21'h000001);
        code_pending.push_back(21'h100000);
        code_pending.push_back(21'h155555);
        code_pending.push_back(21'h000001);
        code_pending.push_back(21'h0AAAAA);
        code_pending.push_back(21'h100000);
        code_pending.push_back(21'h000041);
        code_pending.push_back('0);
        wait_drained();

        // random phases, each one drained before the next
        set_idling(IDLE_NONE);
        queue_random_phase(48, 275);
        wait_drained();

        set_idling(IDLE_SENDER);
        queue_random_phase(300, 275);
        wait_drained();

        set_idling(IDLE_RECEIVER);
        queue_random_phase(240, 275);
        wait_drained();

        set_idling(IDLE_BOTH);
        queue_random_phase(180, 275);
        wait_drained();

        // room for any stray word the block might still produce
        repeat (SLOTS + 16) @(negedge clk);

        if (mismatch_count == 0 && slot_expected.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
